### design/rbfl_pkg.sv
// Shared types and constants for the RBF linear-kernel evaluator.
`default_nettype none
package rbfl_pkg;

	localparam int unsigned COORD_W = 32;
	localparam int unsigned ROOT_W = 34;
	localparam int unsigned RAD_W = 2 * ROOT_W;
	localparam int unsigned REM_W = ROOT_W + 3;
	localparam int unsigned CFG_IDX_W = 3;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ACTIVE = 3'd0,
		CFG_CONST  = 3'd1,
		CFG_AX     = 3'd2,
		CFG_AY     = 3'd3,
		CFG_AZ     = 3'd4
	} cfg_idx_t;

	localparam logic CMD_STORE = 1'b0;
	localparam logic CMD_EVAL = 1'b1;

	typedef struct packed {
		logic               command;
		logic [7:0]         slot;
		logic signed [31:0] coord_x;
		logic signed [31:0] coord_y;
		logic signed [31:0] coord_z;
		logic signed [31:0] weight;
	} in_item_t;

	typedef struct packed {
		logic signed [63:0] value;
		logic               overflow;
	} out_item_t;

	typedef struct packed {
		logic        valid;
		logic [31:0] cx;
		logic [31:0] cy;
		logic [31:0] cz;
		logic [31:0] w;
	} center_t;

	typedef struct packed {
		logic              valid;
		logic [31:0]       w;
		logic [RAD_W-1:0]  rad;
		logic [REM_W-1:0]  rem;
		logic [ROOT_W-1:0] root;
	} cell_t;

endpackage
`default_nettype wire

### design/rbf_linear_kernel_evaluator_top.sv
// Top level of the RBF linear-kernel evaluator: tables, sequencing and accumulator.
//
// A store item (command 0) writes one center and its weight into entry slot in the
// same clock edge at which it is accepted; busy stays low and no result follows.
// An evaluate item (command 1) raises busy. The block reads one center per cycle
// from the tables into a chain of square-root cells, one root bit per cell, then
// multiplies by the weight and adds each term into a saturating 64-bit accumulator
// in index order. After the last center it adds the constant and the three affine
// terms, one per cycle. The result is shown for one cycle with done high, and busy
// falls after it, so the next item can be accepted in the cycle after done.
// With no active centers the cell chain is skipped; the run state goes straight on to
// the constant and affine terms.
// Configuration is written on the cfg channel, which is always ready; it is meant
// to be written only while busy is low. Reset clears the configuration and control
// state; table contents are undefined until stored. The receiver cannot stall.
`default_nettype none
module rbf_linear_kernel_evaluator_top #(
	parameter int unsigned MAX_CENTERS = 256,
	parameter int unsigned FRAC_BITS = 16
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             start,
	output logic                                  busy,
	input  wire rbfl_pkg::in_item_t               request,
	output logic                                  done,
	output rbfl_pkg::out_item_t                   result,
	input  wire logic                             cfg_valid,
	output logic                                  cfg_ready,
	input  wire logic [rbfl_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [31:0]                      cfg_data
);
	localparam int unsigned AW = (MAX_CENTERS > 1) ? $clog2(MAX_CENTERS) : 1;
	localparam int unsigned CW = $clog2(MAX_CENTERS + 1);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_RUN  = 4'b0010,
		ST_AFF  = 4'b0100,
		ST_OUT  = 4'b1000
	} state_t;

	state_t state_q;
	logic [127:0] mem [0:MAX_CENTERS-1];
	logic [8:0] active_q;
	logic signed [31:0] aconst_q, ax_q, ay_q, az_q;
	logic signed [31:0] qx_q, qy_q, qz_q;
	logic [CW-1:0] n_c, issue_q, left_q;
	logic [2:0] aidx_q;
	logic signed [63:0] acc_q;
	logic ovf_q;
	logic [63:0] amag_q [0:2];
	logic signed [63:0] aterm_q [0:2];
	rbfl_pkg::center_t ctr_s1;
	logic ctr_valid_s1;
	logic [127:0] ctr_data_s1;
	logic term_valid;
	logic signed [63:0] term;
	logic signed [63:0] addend;
	logic do_add;
	logic [64:0] sum_c;
	logic signed [63:0] acc_next;
	logic ovf_next;
	logic accept, store_ok;
	logic [31:0] amag_a [0:2];
	logic [31:0] amag_q_in [0:2];
	logic signed [31:0] acoef [0:2];
	logic signed [31:0] qv [0:2];

	assign accept = start && !busy;
	assign store_ok = accept && (request.command == rbfl_pkg::CMD_STORE)
		&& (32'(request.slot) < MAX_CENTERS);
	assign cfg_ready = 1'b1;
	assign busy = (state_q != ST_IDLE);
	assign done = (state_q == ST_OUT);
	assign result.value = acc_q;
	assign result.overflow = ovf_q;
	assign ctr_s1 = {ctr_valid_s1, ctr_data_s1};

	always_comb begin
		if (32'(active_q) > MAX_CENTERS) begin
			n_c = CW'(MAX_CENTERS);
		end else begin
			n_c = CW'(active_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= '0;
			aconst_q <= '0;
			ax_q <= '0;
			ay_q <= '0;
			az_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				rbfl_pkg::CFG_ACTIVE: active_q <= cfg_data[8:0];
				rbfl_pkg::CFG_CONST:  aconst_q <= cfg_data;
				rbfl_pkg::CFG_AX:     ax_q <= cfg_data;
				rbfl_pkg::CFG_AY:     ay_q <= cfg_data;
				rbfl_pkg::CFG_AZ:     az_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (store_ok) begin
			mem[AW'(request.slot)] <= {request.coord_x, request.coord_y, request.coord_z,
				request.weight};
		end
		ctr_data_s1 <= mem[issue_q[AW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (accept && request.command == rbfl_pkg::CMD_EVAL) begin
			qx_q <= request.coord_x;
			qy_q <= request.coord_y;
			qz_q <= request.coord_z;
		end
	end

	always_comb begin
		acoef[0] = ax_q;
		acoef[1] = ay_q;
		acoef[2] = az_q;
		qv[0] = qx_q;
		qv[1] = qy_q;
		qv[2] = qz_q;
		for (int k = 0; k < 3; k++) begin
			amag_a[k] = acoef[k][31] ? 32'(-acoef[k]) : 32'(acoef[k]);
			amag_q_in[k] = qv[k][31] ? 32'(-qv[k]) : 32'(qv[k]);
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < 3; k++) begin
			amag_q[k] <= 64'(amag_a[k]) * 64'(amag_q_in[k]);
			aterm_q[k] <= (acoef[k][31] ^ qv[k][31]) ? -$signed(amag_q[k] >> FRAC_BITS)
				: $signed(amag_q[k] >> FRAC_BITS);
		end
	end

	rbfl_dist_pipe #(.FRAC_BITS(FRAC_BITS)) u_dist (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctr       (ctr_s1),
		.qx        (qx_q),
		.qy        (qy_q),
		.qz        (qz_q),
		.term_valid(term_valid),
		.term      (term)
	);

	always_comb begin
		addend = term;
		do_add = 1'b0;
		if (state_q == ST_RUN) begin
			do_add = term_valid;
		end else if (state_q == ST_AFF) begin
			case (aidx_q)
				3'd2: begin
					addend = 64'(aconst_q);
					do_add = 1'b1;
				end
				3'd3: begin
					addend = aterm_q[0];
					do_add = 1'b1;
				end
				3'd4: begin
					addend = aterm_q[1];
					do_add = 1'b1;
				end
				3'd5: begin
					addend = aterm_q[2];
					do_add = 1'b1;
				end
				default: ;
			endcase
		end
		sum_c = {acc_q[63], acc_q} + {addend[63], addend};
		acc_next = sum_c[63:0];
		ovf_next = ovf_q;
		if (sum_c[64] != sum_c[63]) begin
			acc_next = sum_c[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
			ovf_next = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			issue_q <= '0;
			left_q <= '0;
			aidx_q <= '0;
			acc_q <= '0;
			ovf_q <= 1'b0;
			ctr_valid_s1 <= 1'b0;
		end else begin
			ctr_valid_s1 <= 1'b0;
			if (do_add) begin
				acc_q <= acc_next;
				ovf_q <= ovf_next;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept && request.command == rbfl_pkg::CMD_EVAL) begin
						state_q <= ST_RUN;
						issue_q <= '0;
						left_q <= n_c;
						acc_q <= '0;
						ovf_q <= 1'b0;
					end
				end
				ST_RUN: begin
					if (issue_q != n_c) begin
						issue_q <= issue_q + 1'b1;
						ctr_valid_s1 <= 1'b1;
					end
					if (term_valid) begin
						left_q <= left_q - 1'b1;
					end
					if (left_q == '0) begin
						state_q <= ST_AFF;
						aidx_q <= '0;
					end
				end
				ST_AFF: begin
					aidx_q <= aidx_q + 1'b1;
					if (aidx_q == 3'd5) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n) done |-> busy)
		else $error("done without busy");
	a_done_ends: assert property (@(posedge clk) disable iff (!arst_n) done |=> !busy)
		else $error("busy held after result");
	a_eval_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && request.command == rbfl_pkg::CMD_EVAL) |=> busy)
		else $error("evaluate item did not raise busy");
	a_no_stray_term: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_AFF || state_q == ST_IDLE) |-> !term_valid)
		else $error("distance term outside run phase");
endmodule
`default_nettype wire

### design/rbfl_sqrt_cell.sv
// One square-root cell: resolves one root bit and passes the item on.
`default_nettype none
module rbfl_sqrt_cell (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire rbfl_pkg::cell_t d,
	output rbfl_pkg::cell_t      q
);
	logic [rbfl_pkg::REM_W-1:0] cur;
	logic [rbfl_pkg::REM_W-1:0] trial;
	rbfl_pkg::cell_t nxt;

	always_comb begin
		cur = {d.rem[rbfl_pkg::REM_W-3:0], d.rad[rbfl_pkg::RAD_W-1 -: 2]};
		trial = {1'b0, d.root, 2'b01};
		nxt = d;
		nxt.rad = {d.rad[rbfl_pkg::RAD_W-3:0], 2'b00};
		if (cur >= trial) begin
			nxt.rem = cur - trial;
			nxt.root = {d.root[rbfl_pkg::ROOT_W-2:0], 1'b1};
		end else begin
			nxt.rem = cur;
			nxt.root = {d.root[rbfl_pkg::ROOT_W-2:0], 1'b0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q <= '0;
		end else begin
			q <= nxt;
		end
	end
endmodule
`default_nettype wire

### design/rbfl_dist_pipe.sv
// Distance pipeline: differences, squares, square-root cell chain and weight product.
`default_nettype none
module rbfl_dist_pipe #(
	parameter int unsigned FRAC_BITS = 16
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire rbfl_pkg::center_t  ctr,
	input  wire logic signed [31:0] qx,
	input  wire logic signed [31:0] qy,
	input  wire logic signed [31:0] qz,
	output logic                    term_valid,
	output logic signed [63:0]      term
);
	logic        v_s2, v_s3, v_s4, v_p1, v_p2;
	logic [31:0] w_s2, w_s3, w_s4;
	logic [32:0] dx_s2, dy_s2, dz_s2;
	logic [65:0] sx_s3, sy_s3, sz_s3;
	logic [65:0] sum_s4;
	logic [63:0] prod_p1;
	logic        neg_p1;
	logic signed [63:0] term_p2;
	logic signed [32:0] ex, ey, ez;
	rbfl_pkg::cell_t chain [0:rbfl_pkg::ROOT_W];

	always_comb begin
		ex = $signed({qx[31], qx}) - $signed({ctr.cx[31], ctr.cx});
		ey = $signed({qy[31], qy}) - $signed({ctr.cy[31], ctr.cy});
		ez = $signed({qz[31], qz}) - $signed({ctr.cz[31], ctr.cz});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_p1 <= 1'b0;
			v_p2 <= 1'b0;
		end else begin
			v_s2 <= ctr.valid;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_p1 <= chain[rbfl_pkg::ROOT_W].valid;
			v_p2 <= v_p1;
		end
	end

	always_ff @(posedge clk) begin
		dx_s2 <= ex[32] ? 33'(-ex) : 33'(ex);
		dy_s2 <= ey[32] ? 33'(-ey) : 33'(ey);
		dz_s2 <= ez[32] ? 33'(-ez) : 33'(ez);
		w_s2 <= ctr.w;
		sx_s3 <= 66'(dx_s2) * 66'(dx_s2);
		sy_s3 <= 66'(dy_s2) * 66'(dy_s2);
		sz_s3 <= 66'(dz_s2) * 66'(dz_s2);
		w_s3 <= w_s2;
		sum_s4 <= sx_s3 + sy_s3 + sz_s3;
		w_s4 <= w_s3;
		prod_p1 <= 64'(64'(chain[rbfl_pkg::ROOT_W].w[31] ? 32'(-chain[rbfl_pkg::ROOT_W].w)
			: chain[rbfl_pkg::ROOT_W].w) * 64'(chain[rbfl_pkg::ROOT_W].root[32:0]));
		neg_p1 <= chain[rbfl_pkg::ROOT_W].w[31];
		term_p2 <= neg_p1 ? -$signed(prod_p1 >> FRAC_BITS) : $signed(prod_p1 >> FRAC_BITS);
	end

	always_comb begin
		chain[0].valid = v_s4;
		chain[0].w = w_s4;
		chain[0].rad = {2'b00, sum_s4};
		chain[0].rem = '0;
		chain[0].root = '0;
	end

	for (genvar k = 0; k < rbfl_pkg::ROOT_W; k++) begin : g_cell
		rbfl_sqrt_cell u_cell (
			.clk   (clk),
			.arst_n(arst_n),
			.d     (chain[k]),
			.q     (chain[k+1])
		);
	end

	assign term_valid = v_p2;
	assign term = term_p2;
endmodule
`default_nettype wire
